>>> src/gdc_pkg.sv
// ----------------------------------------------------------------------------
// gdc_pkg
// Shared types, constants and calendar helpers for the date / day index
// converter.
// ----------------------------------------------------------------------------
package gdc_pkg;

  localparam int unsigned FIRST_YEAR    = 1900;
  localparam int unsigned LAST_YEAR_DEF = 2100;
  localparam int unsigned INDEX_W       = 17;
  localparam int unsigned YEAR_W        = 12;
  localparam int unsigned MONTH_W       = 4;
  localparam int unsigned DAY_W         = 5;
  localparam int unsigned LEN_W         = 9;
  localparam logic [INDEX_W-1:0] INDEX_MAX = '1;

  localparam logic FUNC_TO_INDEX = 1'b0;
  localparam logic FUNC_TO_DATE  = 1'b1;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // Year residues of FIRST_YEAR modulo 4, 100 and 400
  localparam logic [1:0] FIRST_MOD4   = 2'(FIRST_YEAR % 4);
  localparam logic [6:0] FIRST_MOD100 = 7'(FIRST_YEAR % 100);
  localparam logic [8:0] FIRST_MOD400 = 9'(FIRST_YEAR % 400);

  typedef struct packed {
    logic             sub;
    logic [LEN_W-1:0] len;
  } alu_ctl_t;

  function automatic logic [LEN_W-1:0] year_len(input logic leap);
    return leap ? 9'd366 : 9'd365;
  endfunction

  function automatic logic [LEN_W-1:0] month_len(input logic leap,
                                                 input logic [MONTH_W-1:0] m);
    logic [LEN_W-1:0] len;
    len = 9'd31;
    if (m == MONTH_FEB) begin
      len = leap ? 9'd29 : 9'd28;
    end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
      len = 9'd30;
    end
    return len;
  endfunction

endpackage

>>> src/gdc_addsub.sv
// ----------------------------------------------------------------------------
// gdc_addsub
// Shared accumulator adder / subtractor; flags no-borrow on subtraction.
// ----------------------------------------------------------------------------
module gdc_addsub #(
  parameter int unsigned ACC_W = 17
) (
  input  logic [ACC_W-1:0]     acc_i,
  input  gdc_pkg::alu_ctl_t    ctl_i,
  output logic [ACC_W-1:0]     res_o,
  output logic                 no_borrow_o
);

  logic [ACC_W-1:0] opnd;
  logic [ACC_W:0]   sum;

  always_comb begin
    opnd = ACC_W'(ctl_i.len);
    if (ctl_i.sub) begin
      opnd = ~opnd;
    end
    sum = {1'b0, acc_i} + {1'b0, opnd} + (ACC_W+1)'(ctl_i.sub);
  end

  assign res_o       = sum[ACC_W-1:0];
  assign no_borrow_o = sum[ACC_W];

endmodule

>>> src/gregorian_date_day_count_converter.sv
// ----------------------------------------------------------------------------
// gregorian_date_day_count_converter
// Date <-> day index (days since 1900-01-01) converter, walking years then
// months through one shared adder / subtractor.
// ----------------------------------------------------------------------------
// Sequence: the accepted item is walked through ST_YEAR, then ST_MONTH, then
//   ST_FIN registers the result into the output register behind m_axis_tvalid.
// Throughput: items are taken one at a time, only in ST_IDLE; the year / month
//   walk on the single adder sets it, and ST_FIN waits while a previous result
//   still holds the output register. A new item is taken while a result still waits.
// Reset: asynchronous, active low; clears sequencer and output valid.
// ----------------------------------------------------------------------------
module gregorian_date_day_count_converter #(
  parameter int unsigned LAST_YEAR = gdc_pkg::LAST_YEAR_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // year[11:0], month[15:12], day[20:16], day_index[37:21]
  input  logic [39:0] s_axis_tdata,
  // func[0]
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_index[16:0], out_year[28:17], out_month[32:29], out_day[37:33]
  output logic [39:0] m_axis_tdata,
  // range_error[0]
  output logic [0:0]  m_axis_tuser
);

  localparam int unsigned ACC_RAW = $clog2((LAST_YEAR - gdc_pkg::FIRST_YEAR + 1) * 366 + 1);
  localparam int unsigned ACC_W   = (ACC_RAW > gdc_pkg::INDEX_W) ? ACC_RAW : gdc_pkg::INDEX_W;
  localparam int unsigned LEAPS   = (LAST_YEAR / 4 - LAST_YEAR / 100 + LAST_YEAR / 400)
                                  - ((gdc_pkg::FIRST_YEAR - 1) / 4
                                  - (gdc_pkg::FIRST_YEAR - 1) / 100
                                  + (gdc_pkg::FIRST_YEAR - 1) / 400);
  localparam int unsigned LAST_IDX = (LAST_YEAR - gdc_pkg::FIRST_YEAR + 1) * 365 + LEAPS - 1;
  localparam logic [ACC_W-1:0] LAST_IDX_A = ACC_W'(LAST_IDX);
  localparam logic [gdc_pkg::YEAR_W-1:0] LAST_Y  = gdc_pkg::YEAR_W'(LAST_YEAR);
  localparam logic [gdc_pkg::YEAR_W-1:0] FIRST_Y = gdc_pkg::YEAR_W'(gdc_pkg::FIRST_YEAR);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_YEAR,
    ST_MONTH,
    ST_FIN
  } state_e;

  state_e                          state_q;
  logic                            dir_q;
  logic                            err_q;
  logic [ACC_W-1:0]                acc_q;
  logic [gdc_pkg::YEAR_W-1:0]      yy_q, tgt_y_q;
  logic [gdc_pkg::MONTH_W-1:0]     mm_q, tgt_m_q;
  logic [1:0]                      c4_q;
  logic [6:0]                      c100_q;
  logic [8:0]                      c400_q;
  logic                            out_valid_q;
  logic [39:0]                     out_data_q;
  logic                            out_err_q;

  logic [gdc_pkg::YEAR_W-1:0]      in_year;
  logic [gdc_pkg::MONTH_W-1:0]     in_month;
  logic [gdc_pkg::DAY_W-1:0]       in_day;
  logic [gdc_pkg::INDEX_W-1:0]     in_index;
  logic                            in_func;
  logic                            in_acc;

  logic                            leap;
  gdc_pkg::alu_ctl_t               ctl;
  logic [ACC_W-1:0]                alu_res;
  logic                            no_borrow;
  logic                            year_step, month_step;
  logic                            out_free;

  logic [gdc_pkg::INDEX_W-1:0]     res_index;
  logic                            res_ovf;
  logic [gdc_pkg::DAY_W-1:0]       res_day;

  assign in_year  = s_axis_tdata[11:0];
  assign in_month = s_axis_tdata[15:12];
  assign in_day   = s_axis_tdata[20:16];
  assign in_index = s_axis_tdata[37:21];
  assign in_func  = s_axis_tuser[0];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign leap = (c100_q == 7'd0) ? (c400_q == 9'd0) : (c4_q == 2'd0);

  always_comb begin
    ctl.sub = dir_q;
    ctl.len = (state_q == ST_MONTH) ? gdc_pkg::month_len(leap, mm_q) : gdc_pkg::year_len(leap);
  end

  gdc_addsub #(
    .ACC_W (ACC_W)
  ) u_addsub (
    .acc_i       (acc_q),
    .ctl_i       (ctl),
    .res_o       (alu_res),
    .no_borrow_o (no_borrow)
  );

  always_comb begin
    if (dir_q == gdc_pkg::FUNC_TO_INDEX) begin
      year_step  = (yy_q < tgt_y_q);
      month_step = (mm_q < tgt_m_q);
    end else begin
      year_step  = (yy_q < LAST_Y) && no_borrow;
      month_step = (mm_q < gdc_pkg::MONTH_DEC) && no_borrow;
    end
  end

  always_comb begin
    res_ovf   = (acc_q > ACC_W'(gdc_pkg::INDEX_MAX));
    res_index = res_ovf ? gdc_pkg::INDEX_MAX : acc_q[gdc_pkg::INDEX_W-1:0];
    res_day   = acc_q[gdc_pkg::DAY_W-1:0] + 5'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dir_q       <= gdc_pkg::FUNC_TO_INDEX;
      err_q       <= 1'b0;
      acc_q       <= '0;
      yy_q        <= FIRST_Y;
      tgt_y_q     <= FIRST_Y;
      mm_q        <= gdc_pkg::MONTH_JAN;
      tgt_m_q     <= gdc_pkg::MONTH_JAN;
      c4_q        <= gdc_pkg::FIRST_MOD4;
      c100_q      <= gdc_pkg::FIRST_MOD100;
      c400_q      <= gdc_pkg::FIRST_MOD400;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            dir_q  <= in_func;
            yy_q   <= FIRST_Y;
            mm_q   <= gdc_pkg::MONTH_JAN;
            c4_q   <= gdc_pkg::FIRST_MOD4;
            c100_q <= gdc_pkg::FIRST_MOD100;
            c400_q <= gdc_pkg::FIRST_MOD400;
            if (in_func == gdc_pkg::FUNC_TO_INDEX) begin
              if (in_year < FIRST_Y) begin
                tgt_y_q <= FIRST_Y;
                err_q   <= 1'b1;
              end else if (in_year > LAST_Y) begin
                tgt_y_q <= LAST_Y;
                err_q   <= 1'b1;
              end else begin
                tgt_y_q <= in_year;
                err_q   <= 1'b0;
              end
              if (in_month == 4'd0) begin
                tgt_m_q <= gdc_pkg::MONTH_JAN;
              end else if (in_month > gdc_pkg::MONTH_DEC) begin
                tgt_m_q <= gdc_pkg::MONTH_DEC;
              end else begin
                tgt_m_q <= in_month;
              end
              acc_q <= (in_day == 5'd0) ? '0 : ACC_W'(in_day - 5'd1);
            end else begin
              tgt_y_q <= LAST_Y;
              tgt_m_q <= gdc_pkg::MONTH_DEC;
              if (ACC_W'(in_index) > LAST_IDX_A) begin
                acc_q <= LAST_IDX_A;
                err_q <= 1'b1;
              end else begin
                acc_q <= ACC_W'(in_index);
                err_q <= 1'b0;
              end
            end
            state_q <= ST_YEAR;
          end
        end
        ST_YEAR: begin
          if (year_step) begin
            acc_q  <= alu_res;
            yy_q   <= yy_q + 12'd1;
            c4_q   <= c4_q + 2'd1;
            c100_q <= (c100_q == 7'd99) ? 7'd0 : c100_q + 7'd1;
            c400_q <= (c400_q == 9'd399) ? 9'd0 : c400_q + 9'd1;
          end else begin
            state_q <= ST_MONTH;
          end
        end
        ST_MONTH: begin
          if (month_step) begin
            acc_q <= alu_res;
            mm_q  <= mm_q + 4'd1;
          end else begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            if (dir_q == gdc_pkg::FUNC_TO_INDEX) begin
              out_data_q <= {23'd0, res_index};
              out_err_q  <= err_q || res_ovf;
            end else begin
              out_data_q <= {2'd0, res_day, mm_q, yy_q, 17'd0};
              out_err_q  <= err_q;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_err_q;

  a_leap_mod4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c4_q == yy_q[1:0])
    else $error("year residue mod 4 out of step with year counter");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_q >= gdc_pkg::MONTH_JAN && mm_q <= gdc_pkg::MONTH_DEC)
    else $error("month counter out of range");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE && dir_q == gdc_pkg::FUNC_TO_DATE) |-> acc_q <= LAST_IDX_A)
    else $error("remaining days exceed last supported index");

  a_out_year: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_free && dir_q == gdc_pkg::FUNC_TO_DATE)
      |=> m_axis_tdata[28:17] >= FIRST_Y && m_axis_tdata[28:17] <= LAST_Y)
    else $error("converted year out of range");

endmodule

>>> test/gregorian_date_day_count_converter_test.sv
// ----------------------------------------------------------------------------
// gregorian_date_day_count_converter_test
// Self-checking bench for the date / day index converter. A directed table
// covers the calendar extremes, clamping and leap cases, then random items
// (mostly valid dates and indexes, some raw field noise) run under three
// stall patterns. Every result is matched in order against a typed golden value
// or a local calendar model; results with no pending item, bad fields and missing results fail.
// ----------------------------------------------------------------------------
module gregorian_date_day_count_converter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned END_YEAR     = gdc_pkg::LAST_YEAR_DEF;
  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned DRAIN_CYCLES = 250;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned NUM_DIR      = 22;

  typedef logic [gdc_pkg::YEAR_W-1:0]  year_t;
  typedef logic [gdc_pkg::MONTH_W-1:0] month_t;
  typedef logic [gdc_pkg::DAY_W-1:0]   day_t;
  typedef logic [gdc_pkg::INDEX_W-1:0] index_t;

  typedef struct packed {
    logic   func;
    year_t  year;
    month_t month;
    day_t   day;
    index_t day_index;
  } conv_req_t;

  typedef struct packed {
    index_t index;
    year_t  year;
    month_t month;
    day_t   day;
    logic   range_err;
  } conv_result_t;

  typedef struct packed {
    conv_req_t    req;
    logic         typed;
    conv_result_t golden;
  } dir_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  conv_result_t pending_results[$];
  int unsigned  src_idle_pct = 25;
  int unsigned  sink_idle_pct = 60;
  int unsigned  cycle_cnt = 0;
  int unsigned  fail_count = 0;
  int unsigned  n_to_index = 0;
  int unsigned  n_to_date = 0;
  int unsigned  n_clamped = 0;
  int unsigned  n_checked = 0;

  // expected result typed in only where it is obvious; the rest is predicted
  dir_row_t dir_table [NUM_DIR] = '{
    '{'{gdc_pkg::FUNC_TO_INDEX, 12'd1900, 4'd1, 5'd1, 17'd0}, 1'b1,
      '{17'd0, 12'd0, 4'd0, 5'd0, 1'b0}},
    '{'{gdc_pkg::FUNC_TO_INDEX, 12'd2100, 4'd12, 5'd31, 17'd0}, 1'b1,
      '{17'd73413, 12'd0, 4'd0, 5'd0, 1'b0}},
    '{'{gdc_pkg::FUNC_TO_INDEX, 12'd0, 4'd1, 5'd1, 17'd0}, 1'b1,
      '{17'd0, 12'd0, 4'd0, 5'd0, 1'b1}},
    '{'{gdc_pkg::FUNC_TO_INDEX, 12'd4095, 4'd15, 5'd31, 17'h1ffff}, 1'b1,
      '{17'd73413, 12'd0, 4'd0, 5'd0, 1'b1}},
    '{'{gdc_pkg::FUNC_TO_INDEX, 12'd1899, 4'd1, 5'd1, 17'd0}, 1'b1,
      '{17'd0, 12'd0, 4'd0, 5'd0, 1'b1}},
    '{'{gdc_pkg::FUNC_TO_INDEX, 12'd2101, 4'd1, 5'd1, 17'd0}, 1'b0, '0},
    '{'{gdc_pkg::FUNC_TO_INDEX, 12'd1900, 4'd0, 5'd0, 17'd0}, 1'b1,
      '{17'd0, 12'd0, 4'd0, 5'd0, 1'b0}},
    '{'{gdc_pkg::FUNC_TO_INDEX, 12'd1900, 4'd3, 5'd1, 17'd0}, 1'b1,
      '{17'd59, 12'd0, 4'd0, 5'd0, 1'b0}},
    '{'{gdc_pkg::FUNC_TO_INDEX, 12'd1900, 4'd2, 5'd31, 17'd0}, 1'b1,
      '{17'd61, 12'd0, 4'd0, 5'd0, 1'b0}},
    '{'{gdc_pkg::FUNC_TO_INDEX, 12'd2000, 4'd2, 5'd29, 17'd0}, 1'b0, '0},
    '{'{gdc_pkg::FUNC_TO_INDEX, 12'd2000, 4'd3, 5'd1, 17'd0}, 1'b0, '0},
    '{'{gdc_pkg::FUNC_TO_INDEX, 12'd1900, 4'd12, 5'd31, 17'd0}, 1'b1,
      '{17'd364, 12'd0, 4'd0, 5'd0, 1'b0}},
    '{'{gdc_pkg::FUNC_TO_INDEX, 12'd2024, 4'd13, 5'd31, 17'd0}, 1'b0, '0},
    '{'{gdc_pkg::FUNC_TO_DATE, 12'd4095, 4'd15, 5'd31, 17'd0}, 1'b1,
      '{17'd0, 12'd1900, 4'd1, 5'd1, 1'b0}},
    '{'{gdc_pkg::FUNC_TO_DATE, 12'd0, 4'd0, 5'd0, 17'd58}, 1'b1,
      '{17'd0, 12'd1900, 4'd2, 5'd28, 1'b0}},
    '{'{gdc_pkg::FUNC_TO_DATE, 12'd0, 4'd0, 5'd0, 17'd59}, 1'b1,
      '{17'd0, 12'd1900, 4'd3, 5'd1, 1'b0}},
    '{'{gdc_pkg::FUNC_TO_DATE, 12'd0, 4'd0, 5'd0, 17'd365}, 1'b1,
      '{17'd0, 12'd1901, 4'd1, 5'd1, 1'b0}},
    '{'{gdc_pkg::FUNC_TO_DATE, 12'd0, 4'd0, 5'd0, 17'd73413}, 1'b1,
      '{17'd0, 12'd2100, 4'd12, 5'd31, 1'b0}},
    '{'{gdc_pkg::FUNC_TO_DATE, 12'd0, 4'd0, 5'd0, 17'd73414}, 1'b1,
      '{17'd0, 12'd2100, 4'd12, 5'd31, 1'b1}},
    '{'{gdc_pkg::FUNC_TO_DATE, 12'd0, 4'd0, 5'd0, 17'h1ffff}, 1'b1,
      '{17'd0, 12'd2100, 4'd12, 5'd31, 1'b1}},
    '{'{gdc_pkg::FUNC_TO_DATE, 12'd0, 4'd0, 5'd0, 17'd36583}, 1'b0, '0},
    '{'{gdc_pkg::FUNC_TO_DATE, 12'd0, 4'd0, 5'd0, 17'd73048}, 1'b0, '0}
  };

  gregorian_date_day_count_converter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  function automatic bit is_leap(int unsigned y);
    if (y % 100 == 0) begin
      return (y % 400) == 0;
    end
    return (y % 4) == 0;
  endfunction

  function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
    if (m == gdc_pkg::MONTH_FEB) begin
      return is_leap(y) ? 29 : 28;
    end
    if (m == gdc_pkg::MONTH_APR || m == gdc_pkg::MONTH_JUN ||
        m == gdc_pkg::MONTH_SEP || m == gdc_pkg::MONTH_NOV) begin
      return 30;
    end
    return 31;
  endfunction

  function automatic int unsigned days_in_year(int unsigned y);
    return is_leap(y) ? 366 : 365;
  endfunction

  function automatic int unsigned days_since_epoch(int unsigned y, int unsigned m,
                                                   int unsigned d);
    int unsigned n;
    n = d - 1;
    for (int unsigned k = 32'(gdc_pkg::MONTH_JAN); k < m; k++) begin
      n += days_in_month(y, k);
    end
    for (int unsigned k = gdc_pkg::FIRST_YEAR; k < y; k++) begin
      n += days_in_year(k);
    end
    return n;
  endfunction

  function automatic conv_result_t predict_conversion(conv_req_t r);
    int unsigned  y;
    int unsigned  m;
    int unsigned  d;
    int unsigned  rest;
    int unsigned  last_day;
    conv_result_t res;
    res = '0;
    last_day = days_since_epoch(END_YEAR, 32'(gdc_pkg::MONTH_DEC), 31);
    if (r.func == gdc_pkg::FUNC_TO_INDEX) begin
      y = 32'(r.year);
      m = 32'(r.month);
      d = 32'(r.day);
      if (y < gdc_pkg::FIRST_YEAR) begin
        y = gdc_pkg::FIRST_YEAR;
        res.range_err = 1'b1;
      end else if (y > END_YEAR) begin
        y = END_YEAR;
        res.range_err = 1'b1;
      end
      if (m == 0) begin
        m = 32'(gdc_pkg::MONTH_JAN);
      end else if (m > gdc_pkg::MONTH_DEC) begin
        m = 32'(gdc_pkg::MONTH_DEC);
      end
      if (d == 0) begin
        d = 1;
      end
      rest = days_since_epoch(y, m, d);
      if (rest > gdc_pkg::INDEX_MAX) begin
        rest = 32'(gdc_pkg::INDEX_MAX);
        res.range_err = 1'b1;
      end
      res.index = index_t'(rest);
    end else begin
      rest = 32'(r.day_index);
      if (rest > last_day) begin
        rest = last_day;
        res.range_err = 1'b1;
      end
      y = gdc_pkg::FIRST_YEAR;
      m = 32'(gdc_pkg::MONTH_JAN);
      while (y < END_YEAR && rest >= days_in_year(y)) begin
        rest -= days_in_year(y);
        y++;
      end
      while (m < gdc_pkg::MONTH_DEC && rest >= days_in_month(y, m)) begin
        rest -= days_in_month(y, m);
        m++;
      end
      res.year  = year_t'(y);
      res.month = month_t'(m);
      res.day   = day_t'(rest + 1);
    end
    return res;
  endfunction

  // mostly valid dates and indexes; the rest carry raw field noise
  function automatic conv_req_t random_request();
    conv_req_t r;
    r.func      = 1'($urandom_range(1));
    r.year      = year_t'($urandom_range(4095));
    r.month     = month_t'($urandom_range(15));
    r.day       = day_t'($urandom_range(31));
    r.day_index = index_t'($urandom_range(131071));
    if ($urandom_range(99) < 80) begin
      r.year  = year_t'($urandom_range(END_YEAR, gdc_pkg::FIRST_YEAR));
      r.month = month_t'($urandom_range(32'(gdc_pkg::MONTH_DEC), 32'(gdc_pkg::MONTH_JAN)));
      r.day   = day_t'($urandom_range(days_in_month(32'(r.year), 32'(r.month)), 1));
      if ($urandom_range(3) == 0) begin
        r.day_index = index_t'(days_since_epoch(32'(r.year), 32'(r.month), 1)
                               - $urandom_range(1));
      end else begin
        r.day_index = index_t'($urandom_range(
                        days_since_epoch(END_YEAR, 32'(gdc_pkg::MONTH_DEC), 31)));
      end
    end
    return r;
  endfunction

  task automatic send_item(input conv_req_t req, input logic typed,
                           input conv_result_t golden);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req.func;
    s_axis_tdata  <= {2'b00, req.day_index, req.day, req.month, req.year};
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    pending_results.push_back(typed ? golden : predict_conversion(req));
    if (req.func == gdc_pkg::FUNC_TO_INDEX) begin
      n_to_index++;
    end else begin
      n_to_date++;
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    conv_result_t got;
    conv_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.index     = m_axis_tdata[16:0];
      got.year      = m_axis_tdata[28:17];
      got.month     = m_axis_tdata[32:29];
      got.day       = m_axis_tdata[37:33];
      got.range_err = m_axis_tuser[0];
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, actual %h/%b", $time,
                 m_axis_tdata, m_axis_tuser);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (want.range_err) begin
          n_clamped++;
        end
        check_field("out_index", 32'(want.index), 32'(got.index));
        check_field("out_year", 32'(want.year), 32'(got.year));
        check_field("out_month", 32'(want.month), 32'(got.month));
        check_field("out_day", 32'(want.day), 32'(got.day));
        check_field("range_error", 32'(want.range_err), 32'(got.range_err));
      end
    end
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < NUM_DIR; i++) begin
      send_item(dir_table[i].req, dir_table[i].typed, dir_table[i].golden);
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        src_idle_pct  = 60;
        sink_idle_pct = 25;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      send_item(random_request(), 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d items sent (%0d date to index, %0d index to date), %0d results checked",
             n_to_index + n_to_date, n_to_index, n_to_date, n_checked);
    $display("%0d results flagged a clamp, %0d mismatches, %0d cycles",
             n_clamped, fail_count, cycle_cnt);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
